// ===== design/csr_pkg.sv =====
// Shared types and constants for the CAN segment reassembler.
// Used by every module of the block; depends on nothing.
package csr_pkg;

    // Result status codes
    localparam logic [2:0] ST_SINGLE  = 3'd0;
    localparam logic [2:0] ST_FIRST   = 3'd1;
    localparam logic [2:0] ST_GENERAL = 3'd2;
    localparam logic [2:0] ST_LAST    = 3'd3;
    localparam logic [2:0] ST_ERROR   = 3'd4;

    // Header and segment byte fields
    localparam logic [5:0] NODE_MASK     = 6'h3F;
    localparam logic [1:0] SEG_TYPE_FIRST = 2'b00;
    localparam logic [1:0] SEG_TYPE_GEN  = 2'b01;
    localparam logic [1:0] SEG_TYPE_LAST = 2'b10;

    localparam logic [3:0] DLC_MAX     = 4'd8;
    localparam logic [2:0] SEG_PAYLOAD = 3'd6;
    localparam logic [6:0] NO_SEQUENCE = 7'd64;
    localparam int         NUM_PAY     = 7;

    // Queue between classifier and state engine
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [10:0] frame_id;
        logic        is_extended;
        logic [3:0]  frame_length;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [8:0] payload_offset;
        logic [2:0] payload_count;
        logic [7:0] pay0;
        logic [7:0] pay1;
        logic [7:0] pay2;
        logic [7:0] pay3;
        logic [7:0] pay4;
        logic [7:0] pay5;
        logic [7:0] pay6;
        logic [8:0] message_length;
        logic [6:0] packets_so_far;
    } t_out_item;

    // Classified frame as it waits for the state engine
    typedef struct packed {
        logic [2:0]                 kind;   // status code before id/sequence checks
        logic [10:0]                frame_id;
        logic [5:0]                 seq;
        logic [2:0]                 count;
        logic [NUM_PAY-1:0][7:0]    pay;
    } t_cls_item;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

endpackage

// ===== design/can_segment_reassembler_top.sv =====
// A result passes through the queue and then the state engine's result register:
// the input transfer writes the queue, and the engine loads its result register when it pops the queue.
// Throughput: one frame per cycle while the output is not stalled.
// A two-entry queue lets input and output stall independently.
// Reset (synchronous, active low) empties the queue and output, clears the
// stored id and length and sets the expected sequence to 64.
module can_segment_reassembler_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  csr_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output csr_pkg::t_out_item o_out_data
);

    csr_pkg::t_cls_item cls;
    csr_pkg::t_cls_item head;
    csr_pkg::t_q_stat   q_stat;
    logic               push;
    logic               pop;

    assign o_in_ready = !q_stat.full;
    assign push       = i_in_valid && o_in_ready;

    csr_front u_front (
        .i_item (i_in_data),
        .o_cls  (cls)
    );

    csr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    csr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== design/csr_front.sv =====
// Frame classifier: header and node-id checks, packet type, payload selection.
// Stateless; depends on csr_pkg.
module csr_front (
    input  csr_pkg::t_in_item  i_item,
    output csr_pkg::t_cls_item o_cls
);

    logic [3:0]  dlc;
    logic        hdr_ok;
    logic [1:0]  seg_type;
    logic        seg_first_idx;  // 1: payload starts at byte1, 0: at byte2
    logic [7:0]  d [8];
    logic [2:0]  kind;
    logic [2:0]  count;
    logic [csr_pkg::NUM_PAY-1:0][7:0] pay;

    assign d[0] = i_item.byte0;
    assign d[1] = i_item.byte1;
    assign d[2] = i_item.byte2;
    assign d[3] = i_item.byte3;
    assign d[4] = i_item.byte4;
    assign d[5] = i_item.byte5;
    assign d[6] = i_item.byte6;
    assign d[7] = i_item.byte7;

    assign dlc      = (i_item.frame_length > csr_pkg::DLC_MAX) ? csr_pkg::DLC_MAX
                                                               : i_item.frame_length;
    assign hdr_ok   = !i_item.is_extended &&
                      ((i_item.frame_id[5:0] & csr_pkg::NODE_MASK) ==
                       (i_item.byte0[5:0] & csr_pkg::NODE_MASK));
    assign seg_type = i_item.byte1[7:6];

    always_comb begin
        kind          = csr_pkg::ST_ERROR;
        count         = 3'd0;
        seg_first_idx = 1'b0;
        if (hdr_ok) begin
            if (!i_item.byte0[7]) begin
                seg_first_idx = 1'b1;
                if (dlc != 4'd0) begin
                    kind  = csr_pkg::ST_SINGLE;
                    count = 3'(dlc - 4'd1);
                end
            end else if (i_item.byte1 == 8'd0 && dlc == csr_pkg::DLC_MAX) begin
                kind  = csr_pkg::ST_FIRST;
                count = csr_pkg::SEG_PAYLOAD;
            end else if (seg_type == csr_pkg::SEG_TYPE_GEN && dlc == csr_pkg::DLC_MAX) begin
                kind  = csr_pkg::ST_GENERAL;
                count = csr_pkg::SEG_PAYLOAD;
            end else if (seg_type == csr_pkg::SEG_TYPE_LAST && dlc >= 4'd2) begin
                kind  = csr_pkg::ST_LAST;
                count = 3'(dlc - 4'd2);
            end
        end
    end

    // Zero bytes beyond the payload count
    always_comb begin
        for (int i = 0; i < csr_pkg::NUM_PAY; i++) begin
            pay[i] = 8'd0;
            if (3'(i) < count) begin
                if (seg_first_idx) begin
                    pay[i] = d[i + 1];
                end else if (i < csr_pkg::NUM_PAY - 1) begin
                    pay[i] = d[i + 2];
                end
            end
        end
    end

    assign o_cls = {kind, i_item.frame_id, i_item.byte1[5:0], count, pay};

endmodule

// ===== design/csr_queue.sv =====
// Short FIFO of classified frames between classifier and state engine.
// Depends on csr_pkg.
module csr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  csr_pkg::t_cls_item i_data,
    input  logic               i_pop,
    output csr_pkg::t_cls_item o_head,
    output csr_pkg::t_q_stat   o_stat
);

    csr_pkg::t_cls_item               r_mem [csr_pkg::QUEUE_DEPTH];
    logic [csr_pkg::QPTR_W-1:0]       r_wptr, n_wptr;
    logic [csr_pkg::QPTR_W-1:0]       r_rptr, n_rptr;
    logic [csr_pkg::QCNT_W-1:0]       r_cnt, n_cnt;

    function automatic logic [csr_pkg::QPTR_W-1:0] ptr_inc(
        input logic [csr_pkg::QPTR_W-1:0] p
    );
        if (p == csr_pkg::QPTR_W'(csr_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + csr_pkg::QPTR_W'(1);
    endfunction

    always_comb begin
        n_wptr = i_push ? ptr_inc(r_wptr) : r_wptr;
        n_rptr = i_pop  ? ptr_inc(r_rptr) : r_rptr;
        n_cnt  = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + csr_pkg::QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - csr_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_head          = r_mem[r_rptr];
    assign o_stat.full     = (r_cnt == csr_pkg::QCNT_W'(csr_pkg::QUEUE_DEPTH));
    assign o_stat.nonempty = (r_cnt != '0);

endmodule

// ===== design/csr_back.sv =====
// State engine: id and sequence checks, message state update, result register.
// Depends on csr_pkg.
module csr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csr_pkg::t_cls_item  i_head,
    input  csr_pkg::t_q_stat    i_q_stat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csr_pkg::t_out_item  o_out_data
);

    logic [10:0]        r_id, n_id;
    logic [6:0]         r_exp, n_exp;
    logic [8:0]         r_len, n_len;
    logic               r_valid;
    csr_pkg::t_out_item r_out, n_out;
    logic               cont_ok;
    logic [2:0]         status;
    logic [8:0]         seq9;

    assign o_pop   = i_q_stat.nonempty && (!r_valid || i_out_ready);
    assign cont_ok = (i_head.frame_id == r_id) && ({1'b0, i_head.seq} == r_exp);
    assign seq9    = {3'b000, i_head.seq};

    always_comb begin
        n_id  = r_id;
        n_exp = r_exp;
        n_len = r_len;
        status = csr_pkg::ST_ERROR;
        case (i_head.kind)
            csr_pkg::ST_SINGLE, csr_pkg::ST_FIRST: begin
                status = i_head.kind;
                n_id   = i_head.frame_id;
                n_exp  = 7'd1;
                n_len  = {6'd0, i_head.count};
            end
            csr_pkg::ST_GENERAL, csr_pkg::ST_LAST: begin
                if (cont_ok) begin
                    status = i_head.kind;
                    n_exp  = r_exp + 7'd1;
                    n_len  = r_len + {6'd0, i_head.count};
                end
            end
            default: begin
                status = csr_pkg::ST_ERROR;
            end
        endcase

        n_out.status         = status;
        n_out.message_length = n_len;
        n_out.packets_so_far = n_exp;
        if (status == csr_pkg::ST_ERROR) begin
            n_out.payload_count  = 3'd0;
            n_out.payload_offset = 9'd0;
            n_out.pay0 = 8'd0;
            n_out.pay1 = 8'd0;
            n_out.pay2 = 8'd0;
            n_out.pay3 = 8'd0;
            n_out.pay4 = 8'd0;
            n_out.pay5 = 8'd0;
            n_out.pay6 = 8'd0;
        end else begin
            n_out.payload_count = i_head.count;
            // sequence * 6 for continuations
            n_out.payload_offset = (status == csr_pkg::ST_GENERAL ||
                                    status == csr_pkg::ST_LAST)
                                   ? (seq9 << 2) + (seq9 << 1) : 9'd0;
            n_out.pay0 = i_head.pay[0];
            n_out.pay1 = i_head.pay[1];
            n_out.pay2 = i_head.pay[2];
            n_out.pay3 = i_head.pay[3];
            n_out.pay4 = i_head.pay[4];
            n_out.pay5 = i_head.pay[5];
            n_out.pay6 = i_head.pay[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id    <= 11'd0;
            r_exp   <= csr_pkg::NO_SEQUENCE;
            r_len   <= 9'd0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_id    <= n_id;
                r_exp   <= n_exp;
                r_len   <= n_len;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the result until transfer
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule

// ===== design/csr_checker.sv =====
// Port-level checks on the CAN segment reassembler, bound to the top level.
// Depends on csr_pkg.
module csr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input csr_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input csr_pkg::t_out_item o_out_data
);

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_error_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == csr_pkg::ST_ERROR |->
            o_out_data.payload_count == 3'd0 && o_out_data.payload_offset == 9'd0)
        else $error("error result carries payload");

    // Single packet restarts the message with its own bytes
    a_single_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == csr_pkg::ST_SINGLE |->
            o_out_data.packets_so_far == 7'd1 &&
            o_out_data.message_length == {6'd0, o_out_data.payload_count} &&
            o_out_data.payload_offset == 9'd0)
        else $error("single packet state mismatch");

    a_first_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == csr_pkg::ST_FIRST |->
            o_out_data.packets_so_far == 7'd1 &&
            o_out_data.message_length == 9'd6 &&
            o_out_data.payload_count == csr_pkg::SEG_PAYLOAD)
        else $error("first packet state mismatch");

endmodule

bind can_segment_reassembler_top csr_checker u_csr_checker (.*);
